// ----- hdl/q9sf_pkg.sv -----
package q9sf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int FW        = 18;          // factor and result width
    localparam int PW        = 2 * FW;      // full product width
    localparam int NODE_W    = 4;
    localparam int NODES     = 9;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    localparam logic signed [PW-1:0] OUT_MIN = -(PW'(65536));
    localparam logic signed [PW-1:0] OUT_MAX = PW'(65536);
    localparam logic signed [PW-1:0] RND     = PW'(1) <<< (FRAC_BITS - 1);

    // factor selector codes per dimension
    localparam logic [1:0] SEL_NEG  = 2'd0;   // node at -1
    localparam logic [1:0] SEL_POS  = 2'd1;   // node at +1
    localparam logic [1:0] SEL_MID  = 2'd2;   // node at 0

    typedef logic signed [FW-1:0] fac_t;

    typedef struct packed {
        fac_t l0;
        fac_t l1;
        fac_t l2;
        fac_t d0;
        fac_t d1;
        fac_t d2;
    } dim_t;

    typedef struct packed {
        dim_t x;
        dim_t y;
    } fset_t;

    function automatic logic [1:0] xi_sel(input logic [NODE_W-1:0] k);
        case (k)
            4'd0, 4'd3, 4'd7: xi_sel = SEL_NEG;
            4'd1, 4'd2, 4'd5: xi_sel = SEL_POS;
            default:          xi_sel = SEL_MID;
        endcase
    endfunction

    function automatic logic [1:0] eta_sel(input logic [NODE_W-1:0] k);
        case (k)
            4'd0, 4'd1, 4'd4: eta_sel = SEL_NEG;
            4'd2, 4'd3, 4'd6: eta_sel = SEL_POS;
            default:          eta_sel = SEL_MID;
        endcase
    endfunction

    function automatic fac_t pick_l(input dim_t d, input logic [1:0] s);
        case (s)
            SEL_NEG: pick_l = d.l0;
            SEL_POS: pick_l = d.l1;
            default: pick_l = d.l2;
        endcase
    endfunction

    function automatic fac_t pick_d(input dim_t d, input logic [1:0] s);
        case (s)
            SEL_NEG: pick_d = d.d0;
            SEL_POS: pick_d = d.d1;
            default: pick_d = d.d2;
        endcase
    endfunction

    // round half up to Q.F, then clamp to the result range
    function automatic fac_t rnd_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        r = (p + RND) >>> FRAC_BITS;
        if (r < OUT_MIN)
            rnd_sat = FW'(OUT_MIN);
        else if (r > OUT_MAX)
            rnd_sat = FW'(OUT_MAX);
        else
            rnd_sat = FW'(r);
    endfunction

endpackage

// ----- hdl/q9sf_front.sv -----
module q9sf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2*q9sf_pkg::IN_W-1:0] in_data,
    output logic                        push_valid,
    input  logic                        push_ready,
    output q9sf_pkg::fset_t             push_data
);
    import q9sf_pkg::*;

    localparam int MW = 34;
    localparam logic signed [MW-1:0] ONE_M   = MW'(1) <<< FRAC_BITS;
    localparam logic signed [MW-1:0] ONE_SQ  = MW'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [MW-1:0] RND_L   = MW'(1) <<< FRAC_BITS;
    localparam logic signed [MW-1:0] RND_M   = MW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [FW-1:0] HALF_F  = FW'(1) <<< (FRAC_BITS - 1);

    logic                   f_valid_reg;
    logic                   f_valid_next;
    logic signed [IN_W-1:0] xi_reg;
    logic signed [IN_W-1:0] eta_reg;

    function automatic dim_t calc_dim(input logic signed [IN_W-1:0] t);
        logic signed [MW-1:0] te;
        logic signed [MW-1:0] pneg;
        logic signed [MW-1:0] ppos;
        logic signed [MW-1:0] pmid;
        logic signed [FW-1:0] tf;
        dim_t                 d;
        te   = MW'(t);
        tf   = FW'(t);
        pneg = (te * (te - ONE_M) + RND_L) >>> (FRAC_BITS + 1);
        ppos = (te * (te + ONE_M) + RND_L) >>> (FRAC_BITS + 1);
        pmid = (ONE_SQ - te * te + RND_M) >>> FRAC_BITS;
        d.l0 = FW'(pneg);
        d.l1 = FW'(ppos);
        d.l2 = FW'(pmid);
        d.d0 = tf - HALF_F;
        d.d1 = tf + HALF_F;
        d.d2 = -(tf <<< 1);
        calc_dim = d;
    endfunction

    assign in_ready   = !f_valid_reg || push_ready;
    assign push_valid = f_valid_reg;

    always_comb
    begin
        push_data.x = calc_dim(xi_reg);
        push_data.y = calc_dim(eta_reg);
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (in_valid && in_ready)
            f_valid_next = 1'b1;
        else if (push_ready)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            xi_reg  <= in_data[IN_W-1:0];
            eta_reg <= in_data[2*IN_W-1:IN_W];
        end
    end

endmodule

// ----- hdl/q9sf_queue.sv -----
module q9sf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  q9sf_pkg::fset_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output q9sf_pkg::fset_t pop_data
);
    import q9sf_pkg::*;

    localparam int DEPTH = 2;

    fset_t       entry_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/q9sf_back.sv -----
module q9sf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    output logic                          head_pop,
    input  q9sf_pkg::fset_t               head_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [q9sf_pkg::NODE_W-1:0]   out_node,
    output q9sf_pkg::fac_t                out_shape,
    output q9sf_pkg::fac_t                out_gxi,
    output q9sf_pkg::fac_t                out_geta,
    output logic                          out_last
);
    import q9sf_pkg::*;

    logic [NODE_W-1:0]    k_reg;
    logic [NODE_W-1:0]    k_next;

    // product stage
    logic                 p_valid_reg;
    logic                 p_valid_next;
    logic [NODE_W-1:0]    p_node_reg;
    logic signed [PW-1:0] p_shape_reg;
    logic signed [PW-1:0] p_gxi_reg;
    logic signed [PW-1:0] p_geta_reg;

    // output stage
    logic                 o_valid_reg;
    logic                 o_valid_next;
    logic [NODE_W-1:0]    o_node_reg;
    fac_t                 o_shape_reg;
    fac_t                 o_gxi_reg;
    fac_t                 o_geta_reg;

    logic                 o_adv;
    logic                 p_adv;
    logic                 issue;
    fac_t                 a;
    fac_t                 da;
    fac_t                 b;
    fac_t                 db;

    assign o_adv    = !o_valid_reg || out_ready;
    assign p_adv    = !p_valid_reg || o_adv;
    assign issue    = head_valid && p_adv;
    assign head_pop = issue && (k_reg == LAST_NODE);

    always_comb
    begin
        a  = pick_l(head_data.x, xi_sel(k_reg));
        da = pick_d(head_data.x, xi_sel(k_reg));
        b  = pick_l(head_data.y, eta_sel(k_reg));
        db = pick_d(head_data.y, eta_sel(k_reg));
    end

    always_comb
    begin
        k_next = k_reg;
        if (issue)
            k_next = (k_reg == LAST_NODE) ? '0 : k_reg + NODE_W'(1);
        p_valid_next = p_adv ? issue : p_valid_reg;
        o_valid_next = o_adv ? p_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg       <= k_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p_node_reg  <= k_reg;
            p_shape_reg <= PW'(a) * PW'(b);
            p_gxi_reg   <= PW'(da) * PW'(b);
            p_geta_reg  <= PW'(a) * PW'(db);
        end
        if (o_adv && p_valid_reg)
        begin
            o_node_reg  <= p_node_reg;
            o_shape_reg <= rnd_sat(p_shape_reg);
            o_gxi_reg   <= rnd_sat(p_gxi_reg);
            o_geta_reg  <= rnd_sat(p_geta_reg);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_node  = o_node_reg;
    assign out_shape = o_shape_reg;
    assign out_gxi   = o_gxi_reg;
    assign out_geta  = o_geta_reg;
    assign out_last  = (o_node_reg == LAST_NODE);

endmodule

// ----- hdl/quad9_shape_function_eval_unit.sv -----
// path: a point is registered in the front end, written into the two-entry queue, and each
//   node result then passes the product stage and the output stage register to m_axis
// throughput: one node result per cycle unless m_axis stalls, set by the back-end sequencer
//   walking the nine nodes through one shared multiply stage; the queue takes new points meanwhile
// reset: rst_n clears the valid flags, the queue pointers and the node counter at once
module quad9_shape_function_eval_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // xi[15:0], eta[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // node[3:0], shape_value[21:4], grad_xi[39:22],
                                         // grad_eta[57:40], zero[63:58]
    output logic        m_axis_tlast
);
    import q9sf_pkg::*;

    logic              push_valid;
    logic              push_ready;
    fset_t             push_data;
    logic              head_valid;
    logic              head_pop;
    fset_t             head_data;
    logic [NODE_W-1:0] node;
    fac_t              shape_value;
    fac_t              grad_xi;
    fac_t              grad_eta;

    q9sf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    q9sf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head_data)
    );

    q9sf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_data  (head_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_node   (node),
        .out_shape  (shape_value),
        .out_gxi    (grad_xi),
        .out_geta   (grad_eta),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, grad_eta, grad_xi, shape_value, node};

endmodule
